// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the allocator RTL.
// Depends on nothing; files that assert take it by include.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define BFPA_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define BFPA_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define BFPA_ASSERT(label, clk, rst, prop, msg)
`define BFPA_NEVER(label, clk, rst, expr, msg)
`endif
`endif

// ----- rtl/bfpa_pkg.sv -----
// Package of the best-fit partition allocator: sizes, control word types
// and the microcode program. Depends on nothing.
`timescale 1ns / 1ps

package bfpa_pkg;

   localparam int MAX_PARTITIONS = 16;
   localparam int SIZE_BITS      = 16;
   localparam int IDX_BITS       = $clog2(MAX_PARTITIONS);
   localparam int COUNT_BITS     = 5;
   localparam int STEP_BITS      = 3;

   localparam logic [COUNT_BITS-1:0] COUNT_RESET = COUNT_BITS'(16);
   localparam logic [COUNT_BITS-1:0] COUNT_MAX   = COUNT_BITS'(MAX_PARTITIONS);
   localparam logic [IDX_BITS-1:0]   LAST_INDEX  = IDX_BITS'(MAX_PARTITIONS - 1);

   // Input mode codes.
   localparam logic MODE_LOAD  = 1'b0;
   localparam logic MODE_ALLOC = 1'b1;

   typedef logic [STEP_BITS-1:0] step_type;

   // Microcode step addresses.
   localparam step_type STEP_FETCH  = 3'd0;
   localparam step_type STEP_PRIME  = 3'd1;
   localparam step_type STEP_SCAN   = 3'd2;
   localparam step_type STEP_DECIDE = 3'd3;
   localparam step_type STEP_GRANT  = 3'd4;
   localparam step_type STEP_NOFIT  = 3'd5;
   localparam step_type STEP_LOAD   = 3'd6;

   // Sequencer branch conditions.
   typedef enum logic [2:0] {
      COND_NEXT     = 3'd0,
      COND_WAIT_REQ = 3'd1,
      COND_LOOP     = 3'd2,
      COND_NOFIT    = 3'd3,
      COND_ALWAYS   = 3'd4
   } cond_type;

   // Memory write selections.
   typedef enum logic [1:0] {
      WR_NONE  = 2'd0,
      WR_LOAD  = 2'd1,
      WR_ALLOC = 2'd2
   } wr_sel_type;

   // Result register selections.
   typedef enum logic [1:0] {
      OUT_NONE  = 2'd0,
      OUT_LOAD  = 2'd1,
      OUT_GRANT = 2'd2,
      OUT_NOFIT = 2'd3
   } out_sel_type;

   // One control word of the program.
   typedef struct packed {
      logic        req_ready;
      logic        rd_en;
      logic        cmp_en;
      wr_sel_type  wr_sel;
      out_sel_type out_sel;
      cond_type    cond;
      step_type    target;
   } ctl_type;

   // The program: fetch, then either a load or prime one read, scan all partitions, decide and commit.
   function automatic ctl_type ucode_rom(input step_type step);
      ctl_type word;
      word = '{req_ready: 1'b0, rd_en: 1'b0, cmp_en: 1'b0, wr_sel: WR_NONE,
               out_sel: OUT_NONE, cond: COND_ALWAYS, target: STEP_FETCH};
      case (step)
         STEP_FETCH: begin
            word.req_ready = 1'b1;
            word.cond      = COND_WAIT_REQ;
            word.target    = STEP_LOAD;
         end
         STEP_PRIME: begin
            word.rd_en = 1'b1;
            word.cond  = COND_NEXT;
         end
         STEP_SCAN: begin
            word.rd_en  = 1'b1;
            word.cmp_en = 1'b1;
            word.cond   = COND_LOOP;
            word.target = STEP_SCAN;
         end
         STEP_DECIDE: begin
            word.cond   = COND_NOFIT;
            word.target = STEP_NOFIT;
         end
         STEP_GRANT: begin
            word.wr_sel  = WR_ALLOC;
            word.out_sel = OUT_GRANT;
         end
         STEP_NOFIT: begin
            word.out_sel = OUT_NOFIT;
         end
         STEP_LOAD: begin
            word.wr_sel  = WR_LOAD;
            word.out_sel = OUT_LOAD;
         end
         default: begin
            word.cond = COND_ALWAYS;
         end
      endcase
      return word;
   endfunction

endpackage

// ----- rtl/bfpa_if.sv -----
// Channel interfaces of the allocator: request, response and register write.
// Depends on bfpa_pkg.
`timescale 1ns / 1ps

interface bfpa_req_if import bfpa_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic                 mode;
   logic [IDX_BITS-1:0]  partition_index;
   logic [SIZE_BITS-1:0] amount;
   modport source (output valid, mode, partition_index, amount, input ready);
   modport sink (input valid, mode, partition_index, amount, output ready);
endinterface

interface bfpa_rsp_if import bfpa_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic                 granted;
   logic [IDX_BITS-1:0]  chosen_index;
   logic [SIZE_BITS-1:0] space_left;
   modport source (output valid, granted, chosen_index, space_left, input ready);
   modport sink (input valid, granted, chosen_index, space_left, output ready);
endinterface

interface bfpa_csr_if import bfpa_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [COUNT_BITS-1:0] partition_count;
   modport source (output valid, partition_count, input ready);
   modport sink (input valid, partition_count, output ready);
endinterface

// ----- rtl/best_fit_partition_allocator.sv -----
// Top level of the best-fit partition allocator: microcoded sequencer,
// remaining-space memory and result register. Depends on bfpa_pkg, bfpa_if
// and assert_macros.svh.
// A load goes from the fetch step through the load step, which writes the
// memory and registers its result. An allocate runs one primed read, a scan
// of all 16 partitions of the remaining-space memory at one read per cycle,
// a decision and a commit step. Synchronous active-high reset clears the
// step counter, valid bits, marks and result valid and sets partition_count
// to 16; space entries that are not valid read as zero.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module best_fit_partition_allocator import bfpa_pkg::*; (
   input  logic clock,
   input  logic reset,
   bfpa_req_if.sink   req_bus,
   bfpa_rsp_if.source rsp_bus,
   bfpa_csr_if.sink   csr_bus
);

   step_type              pc_ff, pc_in;
   ctl_type               ctl;
   logic                  stall;
   logic                  req_accept;

   logic [COUNT_BITS-1:0] count_ff;
   logic [COUNT_BITS-1:0] limit_ff;
   logic [IDX_BITS-1:0]   load_idx_ff;
   logic [SIZE_BITS-1:0]  amount_ff;

   logic [IDX_BITS-1:0]   scan_idx_ff;
   logic [IDX_BITS-1:0]   rd_addr_ff;
   logic [SIZE_BITS-1:0]  rd_data_ff;
   logic                  rd_valid_ff;
   logic                  found_ff;
   logic [IDX_BITS-1:0]   best_idx_ff;
   logic [SIZE_BITS-1:0]  best_space_ff;

   logic [SIZE_BITS-1:0]  space_mem [MAX_PARTITIONS];
   logic [MAX_PARTITIONS-1:0] space_valid_ff;
   logic [MAX_PARTITIONS-1:0] alloc_mark_ff;

   logic                  wr_en;
   logic [IDX_BITS-1:0]   wr_addr;
   logic [SIZE_BITS-1:0]  wr_data;

   logic [SIZE_BITS-1:0]  cand_space;
   logic                  cand_take;
   logic [SIZE_BITS-1:0]  alloc_left;

   logic                  rsp_valid_ff;
   logic                  rsp_granted_ff;
   logic [IDX_BITS-1:0]   rsp_index_ff;
   logic [SIZE_BITS-1:0]  rsp_space_ff;

   // Decode the current control word.
   assign ctl        = ucode_rom(pc_ff);
   assign stall      = (ctl.out_sel != OUT_NONE) && rsp_valid_ff && !rsp_bus.ready;
   assign req_accept = req_bus.valid && req_bus.ready;
   assign req_bus.ready = ctl.req_ready;

   // Register write port is always ready.
   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= COUNT_RESET;
      end else if (csr_bus.valid) begin
         count_ff <= csr_bus.partition_count;
      end
   end

   // Step counter with conditional jumps.
   always_comb begin
      pc_in = pc_ff;
      case (ctl.cond)
         COND_NEXT: begin
            pc_in = pc_ff + step_type'(1);
         end
         COND_WAIT_REQ: begin
            if (req_accept) begin
               pc_in = (req_bus.mode == MODE_LOAD) ? ctl.target : pc_ff + step_type'(1);
            end
         end
         COND_LOOP: begin
            pc_in = (rd_addr_ff != LAST_INDEX) ? ctl.target : pc_ff + step_type'(1);
         end
         COND_NOFIT: begin
            pc_in = !found_ff ? ctl.target : pc_ff + step_type'(1);
         end
         COND_ALWAYS: begin
            pc_in = ctl.target;
         end
         default: begin
            pc_in = STEP_FETCH;
         end
      endcase
      if (stall) begin
         pc_in = pc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= STEP_FETCH;
      end else begin
         pc_ff <= pc_in;
      end
   end

   // Capture the request and clamp the search limit.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         load_idx_ff <= req_bus.partition_index;
         amount_ff   <= req_bus.amount;
         limit_ff    <= (count_ff > COUNT_MAX) ? COUNT_MAX : count_ff;
      end
   end

   // Scan read address walks the partitions one per cycle.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         scan_idx_ff <= '0;
      end else if (ctl.rd_en) begin
         scan_idx_ff <= scan_idx_ff + IDX_BITS'(1);
      end
   end

   // Best-fit compare on the registered read data.
   assign cand_space = rd_valid_ff ? rd_data_ff : '0;
   assign cand_take  = ({1'b0, rd_addr_ff} < limit_ff) && (amount_ff <= cand_space)
                       && (!found_ff || (cand_space < best_space_ff));

   always_ff @(posedge clock) begin
      if (req_accept) begin
         found_ff <= 1'b0;
      end else if (ctl.cmp_en && cand_take) begin
         found_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.cmp_en && cand_take) begin
         best_idx_ff   <= rd_addr_ff;
         best_space_ff <= cand_space;
      end
   end

   // Write port selection for loads and granted allocations.
   assign alloc_left = best_space_ff - amount_ff;
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = load_idx_ff;
      wr_data = amount_ff;
      case (ctl.wr_sel)
         WR_LOAD: begin
            wr_en = !stall;
         end
         WR_ALLOC: begin
            wr_en   = !stall;
            wr_addr = best_idx_ff;
            wr_data = alloc_left;
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   // Remaining-space memory with registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         space_mem[wr_addr] <= wr_data;
      end
      if (ctl.rd_en) begin
         rd_data_ff <= space_mem[scan_idx_ff];
         rd_addr_ff <= scan_idx_ff;
      end
   end

   // Valid bits stand in for the all-zero reset of the memory.
   always_ff @(posedge clock) begin
      if (reset) begin
         space_valid_ff <= '0;
         rd_valid_ff    <= 1'b0;
      end else begin
         if (wr_en) begin
            space_valid_ff[wr_addr] <= 1'b1;
         end
         if (ctl.rd_en) begin
            rd_valid_ff <= space_valid_ff[scan_idx_ff];
         end
      end
   end

   // Allocated marks: a load frees the partition, a grant marks it.
   always_ff @(posedge clock) begin
      if (reset) begin
         alloc_mark_ff <= '0;
      end else if (wr_en) begin
         alloc_mark_ff[wr_addr] <= (ctl.wr_sel == WR_ALLOC);
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if ((ctl.out_sel != OUT_NONE) && !stall) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (!stall) begin
         case (ctl.out_sel)
            OUT_LOAD: begin
               rsp_granted_ff <= 1'b1;
               rsp_index_ff   <= load_idx_ff;
               rsp_space_ff   <= amount_ff;
            end
            OUT_GRANT: begin
               rsp_granted_ff <= 1'b1;
               rsp_index_ff   <= best_idx_ff;
               rsp_space_ff   <= alloc_left;
            end
            OUT_NOFIT: begin
               rsp_granted_ff <= 1'b0;
               rsp_index_ff   <= '0;
               rsp_space_ff   <= '0;
            end
            default: begin
               rsp_granted_ff <= rsp_granted_ff;
            end
         endcase
      end
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.granted      = rsp_granted_ff;
   assign rsp_bus.chosen_index = rsp_index_ff;
   assign rsp_bus.space_left   = rsp_space_ff;

   // A new result appears only after a step that produces one.
   `BFPA_ASSERT(a_rsp_from_step, clock, reset, $rose(rsp_valid_ff) |-> $past(ctl.out_sel != OUT_NONE), "response raised outside an output step")
   // A committed grant leaves its partition marked allocated.
   `BFPA_ASSERT(a_grant_marks, clock, reset, (ctl.wr_sel == WR_ALLOC && !stall) |=> alloc_mark_ff[$past(best_idx_ff)], "granted partition not marked")
   // A grant never takes more space than the chosen partition holds.
   `BFPA_NEVER(a_grant_fits, clock, reset, (pc_ff == STEP_GRANT) && (amount_ff > best_space_ff), "grant exceeds remaining space")

endmodule

// ----- sim/tb_best_fit_partition_allocator.sv -----
// Self-checking testbench of the best-fit partition allocator. A queue-fed driver,
// a response monitor and a built-in best-fit predictor check every transaction.
// Depends on bfpa_pkg, the bfpa channel interfaces and the allocator top level.
`timescale 1ns / 1ps

module tb_best_fit_partition_allocator import bfpa_pkg::*; ();

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int LONG_HOLD      = 300;
   localparam int PHASES         = 10;

   typedef struct packed {
      logic                 mode;
      logic [IDX_BITS-1:0]  partition_index;
      logic [SIZE_BITS-1:0] amount;
      logic                 wait_drain;
   } alloc_req_type;

   typedef struct packed {
      logic                 granted;
      logic [IDX_BITS-1:0]  chosen_index;
      logic [SIZE_BITS-1:0] space_left;
   } grant_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   bfpa_req_if req_bus ();
   bfpa_rsp_if rsp_bus ();
   bfpa_csr_if csr_bus ();

   best_fit_partition_allocator uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus.sink),
      .rsp_bus (rsp_bus.source),
      .csr_bus (csr_bus.sink)
   );

   // Predictor state: remaining space, allocation marks and partition count.
   logic [SIZE_BITS-1:0]  space_copy [MAX_PARTITIONS];
   logic                  mark_copy [MAX_PARTITIONS];
   logic [COUNT_BITS-1:0] count_copy;

   alloc_req_type pending_reqs[$];
   grant_type     expected_grants[$];
   alloc_req_type offered_req;
   logic          offer_busy = 1'b0;

   int send_idle_pct     = 0;
   int rsp_stall_pct     = 0;
   int hold_left         = 0;
   logic long_hold_pending = 1'b0;
   int fail_count        = 0;
   int quiet_cycles      = 0;

   int count_plan [PHASES] = '{0, 1, 31, 16, 17, 5, 9, 2, 13, 16};

   // Clock with a period of 8 ns.
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Best-fit prediction of one transaction; updates the predictor state.
   function automatic grant_type predict_grant(input alloc_req_type req);
      grant_type            res;
      int                   limit;
      int                   j;
      int                   pos;
      bit                   found;
      logic [SIZE_BITS-1:0] best;
      res = '0;
      if (req.mode == MODE_LOAD) begin
         space_copy[req.partition_index] = req.amount;
         mark_copy[req.partition_index]  = 1'b0;
         res.granted      = 1'b1;
         res.chosen_index = req.partition_index;
         res.space_left   = req.amount;
      end else begin
         limit = (int'(count_copy) > MAX_PARTITIONS) ? MAX_PARTITIONS : int'(count_copy);
         found = 1'b0;
         best  = '0;
         pos   = 0;
         for (j = 0; j < limit; j++) begin
            if (req.amount <= space_copy[j] && (!found || space_copy[j] < best)) begin
               found = 1'b1;
               best  = space_copy[j];
               pos   = j;
            end
         end
         // A request that fits nowhere leaves the state untouched.
         if (found) begin
            space_copy[pos]  = space_copy[pos] - req.amount;
            mark_copy[pos]   = 1'b1;
            res.granted      = 1'b1;
            res.chosen_index = IDX_BITS'(pos);
            res.space_left   = space_copy[pos];
         end
      end
      return res;
   endfunction

   task automatic queue_req(input logic mode, input int idx, input int amt,
                            input logic drain);
      pending_reqs.push_back('{mode: mode, partition_index: IDX_BITS'(idx),
                               amount: SIZE_BITS'(amt), wait_drain: drain});
   endtask

   // Random bursts: a few loads followed by several allocations, with some
   // bursts of mixed noise.
   task automatic queue_random(input int n);
      int                   left;
      int                   loads;
      int                   allocs;
      int                   k;
      logic                 noisy;
      logic                 mode;
      logic [SIZE_BITS-1:0] amt;
      left = n;
      while (left > 0) begin
         loads  = $urandom_range(0, 4);
         allocs = $urandom_range(1, 8);
         noisy  = ($urandom_range(0, 9) == 0);
         for (k = 0; k < loads + allocs && left > 0; k++) begin
            mode = noisy ? logic'($urandom_range(0, 1)) : ((k < loads) ? MODE_LOAD : MODE_ALLOC);
            if (mode == MODE_LOAD) begin
               case ($urandom_range(0, 3))
                  0: amt = SIZE_BITS'($urandom);
                  1: amt = SIZE_BITS'(100 * $urandom_range(0, 6));
                  2: amt = $urandom_range(0, 1) ? '1 : '0;
                  default: amt = SIZE_BITS'($urandom_range(0, 1023));
               endcase
            end else begin
               case ($urandom_range(0, 3))
                  0: amt = SIZE_BITS'($urandom_range(0, 255));
                  1: amt = SIZE_BITS'($urandom);
                  2: amt = $urandom_range(0, 1) ? '1 : '0;
                  default: amt = SIZE_BITS'(100 * $urandom_range(0, 6));
               endcase
            end
            queue_req(mode, $urandom_range(0, MAX_PARTITIONS - 1), amt,
                      $urandom_range(0, 99) < 3);
            left--;
         end
      end
   endtask

   // Register write; only issued while the block is idle.
   task automatic write_partition_count(input logic [COUNT_BITS-1:0] value);
      @(posedge clock);
      csr_bus.valid           <= 1'b1;
      csr_bus.partition_count <= value;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
      count_copy = value;
   endtask

   task automatic wait_idle();
      do @(posedge clock);
      while (pending_reqs.size() != 0 || offer_busy || expected_grants.size() != 0);
   endtask

   // Request driver: predicts at acceptance, then offers the next queued item.
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid           <= 1'b0;
         req_bus.mode            <= MODE_LOAD;
         req_bus.partition_index <= '0;
         req_bus.amount          <= '0;
         offer_busy = 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            expected_grants.push_back(predict_grant(offered_req));
            offer_busy = 1'b0;
         end
         if (!offer_busy) begin
            if (pending_reqs.size() > 0 && $urandom_range(0, 99) >= send_idle_pct &&
                !(pending_reqs[0].wait_drain && expected_grants.size() != 0)) begin
               offered_req = pending_reqs.pop_front();
               req_bus.valid           <= 1'b1;
               req_bus.mode            <= offered_req.mode;
               req_bus.partition_index <= offered_req.partition_index;
               req_bus.amount          <= offered_req.amount;
               offer_busy = 1'b1;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // Response monitor: compares each transaction with the oldest expectation.
   always @(posedge clock) begin
      grant_type exp_grant;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         hold_left = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_grants.size() == 0) begin
               $error("unexpected response: granted %0d, chosen_index %0d, space_left %0d",
                      rsp_bus.granted, rsp_bus.chosen_index, rsp_bus.space_left);
               fail_count++;
            end else begin
               exp_grant = expected_grants.pop_front();
               if (rsp_bus.granted !== exp_grant.granted) begin
                  $error("granted: expected %0d, actual %0d",
                         exp_grant.granted, rsp_bus.granted);
                  fail_count++;
               end
               if (rsp_bus.chosen_index !== exp_grant.chosen_index) begin
                  $error("chosen_index: expected %0d, actual %0d",
                         exp_grant.chosen_index, rsp_bus.chosen_index);
                  fail_count++;
               end
               if (rsp_bus.space_left !== exp_grant.space_left) begin
                  $error("space_left: expected %0d, actual %0d",
                         exp_grant.space_left, rsp_bus.space_left);
                  fail_count++;
               end
            end
         end
         // Long hold-off when requested, otherwise random stalls.
         if (hold_left > 0) begin
            rsp_bus.ready <= 1'b0;
            hold_left--;
         end else if (long_hold_pending) begin
            rsp_bus.ready <= 1'b0;
            hold_left = LONG_HOLD;
            long_hold_pending = 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
         end
      end
   end

   // Watchdog on cycles with no transaction on any channel.
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (csr_bus.valid && csr_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("tb_best_fit_partition_allocator: errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Sequence of phases.
   initial begin
      int p;
      csr_bus.valid           = 1'b0;
      csr_bus.partition_count = '0;
      for (p = 0; p < MAX_PARTITIONS; p++) begin
         space_copy[p] = '0;
         mark_copy[p]  = 1'b0;
      end
      count_copy = COUNT_RESET;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed part with all partitions searched.
      write_partition_count(COUNT_BITS'(16));
      queue_req(MODE_ALLOC, 0, 0, 1'b0);       // zero request fits an empty partition
      queue_req(MODE_ALLOC, 0, 1, 1'b0);       // nothing fits
      queue_req(MODE_LOAD, 15, 65535, 1'b0);
      queue_req(MODE_LOAD, 0, 0, 1'b0);
      queue_req(MODE_LOAD, 3, 100, 1'b0);
      queue_req(MODE_LOAD, 7, 100, 1'b0);
      queue_req(MODE_ALLOC, 9, 50, 1'b0);      // tie between two, lowest index wins
      queue_req(MODE_ALLOC, 0, 50, 1'b0);      // exact fit
      queue_req(MODE_ALLOC, 0, 100, 1'b0);
      queue_req(MODE_ALLOC, 0, 65535, 1'b0);   // largest request
      queue_req(MODE_ALLOC, 0, 65535, 1'b0);   // largest request, nothing left
      queue_req(MODE_LOAD, 15, 65535, 1'b0);
      queue_req(MODE_ALLOC, 0, 0, 1'b0);
      queue_req(MODE_LOAD, 5, 65535, 1'b0);
      queue_req(MODE_ALLOC, 0, 65534, 1'b0);
      queue_req(MODE_ALLOC, 15, 1, 1'b1);      // wait for all results first
      queue_req(MODE_LOAD, 10, 21845, 1'b0);
      queue_req(MODE_LOAD, 5, 43690, 1'b0);
      queue_req(MODE_ALLOC, 0, 21845, 1'b0);
      wait_idle();

      // Random phases over several partition counts and idling patterns.
      for (p = 0; p < PHASES; p++) begin
         case (p % 4)
            0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_idle_pct = 60; rsp_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct = 60; end
            default: begin send_idle_pct = 16; rsp_stall_pct = 16; end
         endcase
         write_partition_count(COUNT_BITS'(count_plan[p]));
         queue_random(68);
         if (p == 4) long_hold_pending = 1'b1;
         wait_idle();
      end

      repeat (40) @(posedge clock);
      if (fail_count == 0) begin
         $display("tb_best_fit_partition_allocator: clean");
      end else begin
         $display("tb_best_fit_partition_allocator: errors");
      end
      $finish;
   end

endmodule

// ----- best_fit_partition_allocator.f -----
+incdir+rtl
rtl/bfpa_pkg.sv
rtl/bfpa_if.sv
rtl/best_fit_partition_allocator.sv
sim/tb_best_fit_partition_allocator.sv
